// ===== sv/pitr_pkg.sv =====
// Package with the shared types, constants and helpers of the port hold/release tracker.
package pitr_pkg;

  localparam int unsigned ChanCnt = 8;
  localparam int unsigned ChanW   = (ChanCnt > 1) ? $clog2(ChanCnt) : 1;
  localparam int unsigned CntW    = $clog2(ChanCnt + 1);
  localparam int unsigned PortW   = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned MapW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned StatW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INPUT_COUNT  = 3'd0,
    CFG_CHANNEL_MAP  = 3'd1,
    CFG_OUTPUT_MASK  = 3'd2,
    CFG_ACTIVE_HIGH  = 3'd3
  } cfg_idx_e;

  typedef enum logic [StatW-1:0] {
    ST_NONE     = 2'd0,
    ST_HELD     = 2'd1,
    ST_RELEASED = 2'd2
  } status_e;

  // One entry of the channel state memory.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] duration;
  } chan_entry_t;

  localparam int unsigned EntryW = $bits(chan_entry_t);

  // True when the selected port bit is at its active level.
  function automatic logic bit_active(input logic [PortW-1:0] port,
                                      input logic [PosW-1:0]  pos,
                                      input logic             act_high);
    logic b;
    b = port[pos];
    return act_high ? b : ~b;
  endfunction

endpackage

// ===== sv/pitr_if.sv =====
// Handshake interfaces for the sample input channel and the channel result output.
interface pitr_in_if;
  logic                           valid;
  logic                           ready;
  logic [pitr_pkg::PortW-1:0]     port_value;
  logic [pitr_pkg::TimeW-1:0]     now_ms;

  modport source (output valid, output port_value, output now_ms, input ready);
  modport sink   (input valid, input port_value, input now_ms, output ready);
endinterface

interface pitr_out_if;
  logic                           valid;
  logic                           ready;
  logic [pitr_pkg::ChanW-1:0]     channel;
  logic [pitr_pkg::StatW-1:0]     status;
  logic [pitr_pkg::TimeW-1:0]     duration_ms;
  logic                           last;

  modport source (output valid, output channel, output status, output duration_ms,
                  output last, input ready);
  modport sink   (input valid, input channel, input status, input duration_ms,
                  input last, output ready);
endinterface

// ===== sv/pitr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pitr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/port_input_hold_release_tracker.sv =====
// Top level of the port input hold/release tracker: sequencer, state memory and result register.
//
// The block takes one beat on in_i carrying an 8-bit port sample and a wrapping
// millisecond time. Port bits named in the output mask are forced to one. When the
// forced sample equals the stored previous sample, the beat produces nothing.
// Otherwise every configured input channel is visited in order, its state entry is
// read from the channel memory, updated and written back, and one beat per channel
// goes out on out_o with the channel index, its status, its hold duration and a
// last flag on the final channel.
// An accepted changing beat moves the sequencer to its run state while channel zero is
// read from the memory; the first result is registered once the result register can
// take it. One channel is handled per cycle unless the receiver stalls; a new beat is
// taken only after the last configured channel (up to eight) retires. A sample that
// does not change, or a change with no channels configured, is taken in the idle state.
// When the receiver stalls, the sequencer holds on the current channel and keeps
// rereading its entry until the result register can take the next beat.
// Reset clears all configuration registers, sets the previous sample to all ones and
// marks every memory entry as unwritten, which reads as status none with zero start
// time and duration. No clearing pass is needed. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_data_i; the user must write it only while the block is
// idle, which the block itself does not enforce. Unknown indexes are ignored.
module port_input_hold_release_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pitr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pitr_pkg::CfgW-1:0]        cfg_data_i,
  pitr_in_if.sink                          in_i,
  pitr_out_if.source                       out_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  // Configuration registers.
  logic [pitr_pkg::CntW-1:0]   in_count_q;
  logic [pitr_pkg::MapW-1:0]   chan_map_q;
  logic [pitr_pkg::PortW-1:0]  out_mask_q;
  logic                        act_high_q;

  // Sequencer state.
  state_e                      state_q, state_d;
  logic [pitr_pkg::ChanW-1:0]  idx_q, idx_d;
  logic [pitr_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [pitr_pkg::PortW-1:0]  prev_q, prev_d;
  logic [pitr_pkg::PortW-1:0]  sample_q, sample_d;
  logic [pitr_pkg::TimeW-1:0]  now_q, now_d;
  logic [pitr_pkg::ChanCnt-1:0] vld_q, vld_d;
  logic                        rd_vld_q;

  // Result register.
  logic                        ovalid_q, ovalid_d;
  logic [pitr_pkg::ChanW-1:0]  ochan_q;
  logic [pitr_pkg::StatW-1:0]  ostat_q;
  logic [pitr_pkg::TimeW-1:0]  odur_q;
  logic                        olast_q;

  logic [pitr_pkg::PortW-1:0]  in_sample;
  logic [pitr_pkg::CntW-1:0]   cnt_eff;
  logic                        accept;
  logic                        advance;
  logic                        is_last;
  logic [pitr_pkg::ChanW-1:0]  rd_addr;
  logic [pitr_pkg::EntryW-1:0] rd_raw;
  pitr_pkg::chan_entry_t       cur_entry;
  pitr_pkg::chan_entry_t       new_entry;
  logic [pitr_pkg::PosW-1:0]   pos;
  logic                        was_act;
  logic                        now_act;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q <= '0;
      chan_map_q <= '0;
      out_mask_q <= '0;
      act_high_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (pitr_pkg::cfg_idx_e'(cfg_idx_i))
        pitr_pkg::CFG_INPUT_COUNT: in_count_q <= cfg_data_i[pitr_pkg::CntW-1:0];
        pitr_pkg::CFG_CHANNEL_MAP: chan_map_q <= cfg_data_i[pitr_pkg::MapW-1:0];
        pitr_pkg::CFG_OUTPUT_MASK: out_mask_q <= cfg_data_i[pitr_pkg::PortW-1:0];
        pitr_pkg::CFG_ACTIVE_HIGH: act_high_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Forced sample and the channel count clamped to the number of channels.
  assign in_sample = in_i.port_value | out_mask_q;
  assign cnt_eff   = (in_count_q > pitr_pkg::CntW'(pitr_pkg::ChanCnt))
                   ? pitr_pkg::CntW'(pitr_pkg::ChanCnt) : in_count_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // The result register can take a new beat when empty or being drained.
  assign advance = (state_q == S_RUN) && (!ovalid_q || out_o.ready);
  assign is_last = ({1'b0, idx_q} + pitr_pkg::CntW'(1)) == cnt_q;

  // Read address: channel zero at the start of a sample, then the next channel when
  // the current one retires, else the current one again to keep its data in place.
  always_comb begin
    if (state_q == S_RUN) begin
      rd_addr = advance ? (idx_q + pitr_pkg::ChanW'(1)) : idx_q;
    end else begin
      rd_addr = '0;
    end
  end

  pitr_ram #(
    .Width (pitr_pkg::EntryW),
    .Depth (pitr_pkg::ChanCnt)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (advance),
    .waddr_i (idx_q),
    .wdata_i (new_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  // An entry never written since reset reads as its reset value.
  assign cur_entry = rd_vld_q ? pitr_pkg::chan_entry_t'(rd_raw) : '0;

  // Channel update: edge classification against the previous sample.
  always_comb begin
    pos       = chan_map_q[pitr_pkg::PosW*idx_q +: pitr_pkg::PosW];
    was_act   = pitr_pkg::bit_active(prev_q, pos, act_high_q);
    now_act   = pitr_pkg::bit_active(sample_q, pos, act_high_q);
    new_entry = cur_entry;
    unique case ({was_act, now_act})
      2'b01: begin
        new_entry.status   = pitr_pkg::ST_HELD;
        new_entry.start    = now_q;
        new_entry.duration = '0;
      end
      2'b10: begin
        new_entry.status   = pitr_pkg::ST_RELEASED;
        new_entry.duration = now_q - cur_entry.start;
      end
      2'b00: begin
        new_entry.status = pitr_pkg::ST_NONE;
      end
      default: ;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    prev_d   = prev_q;
    sample_d = sample_q;
    now_d    = now_q;
    vld_d    = vld_q;
    ovalid_d = ovalid_q && !out_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_sample != prev_q)) begin
          if (cnt_eff == '0) begin
            prev_d = in_sample;
          end else begin
            state_d  = S_RUN;
            idx_d    = '0;
            cnt_d    = cnt_eff;
            sample_d = in_sample;
            now_d    = in_i.now_ms;
          end
        end
      end
      S_RUN: begin
        if (advance) begin
          ovalid_d     = 1'b1;
          vld_d[idx_q] = 1'b1;
          if (is_last) begin
            state_d = S_IDLE;
            prev_d  = sample_q;
          end else begin
            idx_d = idx_q + pitr_pkg::ChanW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      prev_q   <= '1;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      prev_q   <= prev_d;
      vld_q    <= vld_d;
      rd_vld_q <= vld_q[rd_addr];
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    now_q    <= now_d;
    if (advance) begin
      ochan_q <= idx_q;
      ostat_q <= new_entry.status;
      odur_q  <= new_entry.duration;
      olast_q <= is_last;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.channel     = ochan_q;
  assign out_o.status      = ostat_q;
  assign out_o.duration_ms = odur_q;
  assign out_o.last        = olast_q;

endmodule
